FILE: src/cbc_pkg.sv
// Package for the cartridge bank controller: controller kinds, target codes,
// configuration register indexes and the fixed widths of the bus and banks.
// No dependencies.
`default_nettype none

package cbc_pkg;

	// controller kinds
	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_FIRST = 2'd1,
		KIND_THIRD = 2'd2,
		KIND_FIFTH = 2'd3
	} kind_t;

	// result targets
	typedef enum logic [1:0] {
		TGT_NONE = 2'd0,
		TGT_ROM  = 2'd1,
		TGT_RAM  = 2'd2,
		TGT_RTC  = 2'd3
	} target_t;

	// configuration register indexes
	localparam logic [1:0] CFG_KIND      = 2'd0;
	localparam logic [1:0] CFG_ROM_COUNT = 2'd1;
	localparam logic [1:0] CFG_RAM_COUNT = 2'd2;
	localparam logic [1:0] CFG_HAS_RAM   = 2'd3;

	// bus address regions, by address bits 15..13
	localparam logic [2:0] REG_RAM_EN    = 3'd0;
	localparam logic [2:0] REG_ROM_BANK  = 3'd1;
	localparam logic [2:0] REG_RAM_BANK  = 3'd2;
	localparam logic [2:0] REG_MODE      = 3'd3;
	localparam logic [2:0] REG_EXT_RAM   = 3'd5;

	localparam int ADDR_W      = 16;
	localparam int DATA_W      = 8;
	localparam int PHYS_W      = 23;
	localparam int CFG_W       = 10;
	localparam int ROM_BANK_W  = 9;
	localparam int ROM_OFF_W   = 14;
	localparam int RAM_OFF_W   = 13;
	localparam int RAM_BANK_W  = 4;
	localparam int RTC_REGS    = 5;
	localparam int RTC_IDX_W   = 3;

	localparam logic [DATA_W-1:0] UNMAPPED_READ = 8'hff;
	localparam logic [DATA_W-1:0] FIRST_MASK    = 8'h1f;
	localparam logic [DATA_W-1:0] THIRD_MASK    = 8'h7f;
	localparam logic [DATA_W-1:0] RTC_SEL_LO    = 8'h08;
	localparam logic [DATA_W-1:0] RTC_SEL_HI    = 8'h0c;

endpackage

`default_nettype wire

FILE: src/cartridge_bank_controller.sv
// Cartridge bank controller top level: bank registers, address translation
// and the RTC register file. Depends on cbc_pkg.
`default_nettype none

// One bus access word enters and one result word leaves per cycle while
// out_ready stays high; a word passes through the input register, then the
// result register, and the bank registers change when a write word passes
// from the first to the second. in_ready drops only while both registers
// are full and out_ready is low. Configuration is written through cfg_we /
// cfg_index / cfg_data and must only change while no word is in flight.
module cartridge_bank_controller (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          mode,
	input  wire logic [cbc_pkg::ADDR_W-1:0]    bus_address,
	input  wire logic [cbc_pkg::DATA_W-1:0]    write_byte,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [1:0]                         target,
	output logic [cbc_pkg::PHYS_W-1:0]         physical_address,
	output logic [cbc_pkg::DATA_W-1:0]         read_value,
	output logic                               value_from_block,
	input  wire logic                          cfg_we,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [cbc_pkg::CFG_W-1:0]     cfg_data
);

	// configuration registers
	cbc_pkg::kind_t                  kind_q;
	logic [9:0]                      rom_count_q;
	logic [4:0]                      ram_count_q;
	logic                            has_ram_q;

	// bank state
	logic [cbc_pkg::ROM_BANK_W-1:0]  rom_low_q;
	logic [1:0]                      rom_upper_q;
	logic                            bank_mode_q;
	logic [1:0]                      ram_first_q;
	logic [cbc_pkg::DATA_W-1:0]      rtc_sel_q;
	logic [cbc_pkg::RAM_BANK_W-1:0]  ram_fifth_q;
	logic [cbc_pkg::DATA_W-1:0]      rtc_q [cbc_pkg::RTC_REGS];

	// input register
	logic                            valid_s1;
	logic                            mode_s1;
	logic [cbc_pkg::ADDR_W-1:0]      addr_s1;
	logic [cbc_pkg::DATA_W-1:0]      byte_s1;

	// result register
	logic                            valid_q;
	cbc_pkg::target_t                target_q;
	logic [cbc_pkg::PHYS_W-1:0]      phys_q;
	logic [cbc_pkg::DATA_W-1:0]      value_q;
	logic                            fb_q;

	logic                            out_free;
	logic                            advance;

	// combinational result and next state
	cbc_pkg::target_t                res_target;
	logic [cbc_pkg::PHYS_W-1:0]      res_phys;
	logic [cbc_pkg::DATA_W-1:0]      res_value;
	logic                            res_fb;
	logic [cbc_pkg::ROM_BANK_W-1:0]  nxt_rom_low;
	logic [1:0]                      nxt_rom_upper;
	logic                            nxt_bank_mode;
	logic [1:0]                      nxt_ram_first;
	logic [cbc_pkg::DATA_W-1:0]      nxt_rtc_sel;
	logic [cbc_pkg::RAM_BANK_W-1:0]  nxt_ram_fifth;
	logic                            rtc_we;

	logic [9:0]                      rom_count_m1;
	logic [4:0]                      ram_count_m1;
	logic [cbc_pkg::RTC_IDX_W-1:0]   rtc_idx;
	logic                            rtc_sel_ok;

	assign out_free = !valid_q || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	assign rom_count_m1 = rom_count_q - 10'd1;
	assign ram_count_m1 = ram_count_q - 5'd1;
	assign rtc_idx      = rtc_sel_q[cbc_pkg::RTC_IDX_W-1:0];
	assign rtc_sel_ok   = (rtc_sel_q >= cbc_pkg::RTC_SEL_LO) && (rtc_sel_q <= cbc_pkg::RTC_SEL_HI);

	// decode of one bus access
	always_comb begin
		logic [cbc_pkg::DATA_W-1:0]      bank_byte;
		logic [cbc_pkg::ROM_BANK_W-1:0]  rom_bank;
		logic [cbc_pkg::RAM_BANK_W-1:0]  ram_bank;

		res_target    = cbc_pkg::TGT_NONE;
		res_phys      = '0;
		res_value     = '0;
		res_fb        = 1'b0;
		nxt_rom_low   = rom_low_q;
		nxt_rom_upper = rom_upper_q;
		nxt_bank_mode = bank_mode_q;
		nxt_ram_first = ram_first_q;
		nxt_rtc_sel   = rtc_sel_q;
		nxt_ram_fifth = ram_fifth_q;
		rtc_we        = 1'b0;
		bank_byte     = (byte_s1 == '0) ? 8'd1 : byte_s1;
		rom_bank      = rom_low_q;
		ram_bank      = '0;

		if (!addr_s1[15]) begin
			if (mode_s1) begin
				// bank register writes
				case (addr_s1[15:13])
					cbc_pkg::REG_ROM_BANK: begin
						case (kind_q)
							cbc_pkg::KIND_FIFTH: begin
								if (!addr_s1[12])
									nxt_rom_low = {rom_low_q[8], byte_s1};
								else
									nxt_rom_low = {byte_s1[0], rom_low_q[7:0]};
							end
							cbc_pkg::KIND_FIRST:
								nxt_rom_low = {1'b0, bank_byte & cbc_pkg::FIRST_MASK};
							cbc_pkg::KIND_THIRD:
								nxt_rom_low = {1'b0, bank_byte & cbc_pkg::THIRD_MASK};
							default:
								nxt_rom_low = {1'b0, bank_byte};
						endcase
					end
					cbc_pkg::REG_RAM_BANK: begin
						case (kind_q)
							cbc_pkg::KIND_FIRST: begin
								if (!bank_mode_q)
									nxt_rom_upper = byte_s1[1:0];
								else if (ram_count_q == 5'd1)
									nxt_ram_first = {1'b0, byte_s1[0]};
								else
									nxt_ram_first = byte_s1[1:0];
							end
							cbc_pkg::KIND_THIRD:
								nxt_rtc_sel = byte_s1;
							cbc_pkg::KIND_FIFTH:
								nxt_ram_fifth = byte_s1[3:0] & ram_count_m1[3:0];
							default: ;
						endcase
					end
					cbc_pkg::REG_MODE: begin
						if (kind_q == cbc_pkg::KIND_FIRST)
							nxt_bank_mode = byte_s1[0];
					end
					default: ;
				endcase
			end else if (!addr_s1[14]) begin
				// fixed ROM bank
				res_target = cbc_pkg::TGT_ROM;
				res_phys   = {{(cbc_pkg::PHYS_W-cbc_pkg::ADDR_W){1'b0}}, addr_s1};
			end else begin
				// switchable ROM bank
				if (kind_q == cbc_pkg::KIND_FIRST && !bank_mode_q)
					rom_bank = rom_low_q | {2'b00, rom_upper_q, 5'b00000};
				rom_bank   = rom_bank & rom_count_m1[cbc_pkg::ROM_BANK_W-1:0];
				res_target = cbc_pkg::TGT_ROM;
				res_phys   = {rom_bank, addr_s1[cbc_pkg::ROM_OFF_W-1:0]};
			end
		end else if (addr_s1[15:13] == cbc_pkg::REG_EXT_RAM) begin
			// external RAM or RTC window
			if (kind_q == cbc_pkg::KIND_FIRST || kind_q == cbc_pkg::KIND_FIFTH) begin
				if (!has_ram_q) begin
					res_fb    = !mode_s1;
					res_value = mode_s1 ? 8'h00 : cbc_pkg::UNMAPPED_READ;
				end else begin
					if (kind_q == cbc_pkg::KIND_FIRST)
						ram_bank = bank_mode_q ? {2'b00, ram_first_q} : '0;
					else
						ram_bank = ram_fifth_q;
					res_target = cbc_pkg::TGT_RAM;
					res_phys   = {6'd0, ram_bank, addr_s1[cbc_pkg::RAM_OFF_W-1:0]};
				end
			end else if (kind_q == cbc_pkg::KIND_THIRD && rtc_sel_q[7:2] == '0) begin
				res_target = cbc_pkg::TGT_RAM;
				res_phys   = {8'd0, rtc_sel_q[1:0], addr_s1[cbc_pkg::RAM_OFF_W-1:0]};
			end else if (kind_q == cbc_pkg::KIND_THIRD && rtc_sel_ok) begin
				res_target = cbc_pkg::TGT_RTC;
				res_phys   = {{(cbc_pkg::PHYS_W-cbc_pkg::RTC_IDX_W){1'b0}}, rtc_idx};
				if (mode_s1) begin
					rtc_we = 1'b1;
				end else begin
					res_value = rtc_q[rtc_idx];
					res_fb    = 1'b1;
				end
			end else begin
				res_fb = !mode_s1;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q      <= cbc_pkg::KIND_NONE;
			rom_count_q <= 10'd2;
			ram_count_q <= 5'd1;
			has_ram_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				cbc_pkg::CFG_KIND:      kind_q      <= cbc_pkg::kind_t'(cfg_data[1:0]);
				cbc_pkg::CFG_ROM_COUNT: rom_count_q <= cfg_data;
				cbc_pkg::CFG_RAM_COUNT: ram_count_q <= cfg_data[4:0];
				cbc_pkg::CFG_HAS_RAM:   has_ram_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// bank state, updated as a word moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_low_q   <= '0;
			rom_upper_q <= '0;
			bank_mode_q <= 1'b0;
			ram_first_q <= '0;
			rtc_sel_q   <= '0;
			ram_fifth_q <= '0;
			for (int i = 0; i < cbc_pkg::RTC_REGS; i++)
				rtc_q[i] <= '0;
		end else if (advance) begin
			rom_low_q   <= nxt_rom_low;
			rom_upper_q <= nxt_rom_upper;
			bank_mode_q <= nxt_bank_mode;
			ram_first_q <= nxt_ram_first;
			rtc_sel_q   <= nxt_rtc_sel;
			ram_fifth_q <= nxt_ram_fifth;
			if (rtc_we)
				rtc_q[rtc_idx] <= byte_s1;
		end
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1 <= mode;
			addr_s1 <= bus_address;
			byte_s1 <= write_byte;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (out_free)
			valid_q <= valid_s1;
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			target_q <= res_target;
			phys_q   <= res_phys;
			value_q  <= res_value;
			fb_q     <= res_fb;
		end
	end

	assign out_valid        = valid_q;
	assign target           = target_q;
	assign physical_address = phys_q;
	assign read_value       = value_q;
	assign value_from_block = fb_q;

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench for cartridge_bank_controller: a directed table, then random bus access words
// under several bank settings, checked against typed values or an in-house bank decoder model.
// Depends on cbc_pkg and the cartridge_bank_controller top level.

module tb;
	import cbc_pkg::*;

	localparam int LONG_HOLD  = 60;
	localparam int N_PHASES   = 9;
	localparam int PHASE_WORDS = 58;

	typedef struct packed {
		target_t           tgt;
		logic [PHYS_W-1:0] paddr;
		logic [DATA_W-1:0] rval;
		logic              fb;
	} bus_result_t;

	typedef enum logic [1:0] {ROW_CFG, ROW_PREDICT, ROW_TYPED} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic [1:0]        idx;
		logic [CFG_W-1:0]  cfg_val;
		logic              wr;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
		bus_result_t       known;
	} stim_row_t;

	// clock, reset and block inputs
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic mode = 1'b0;
	logic [ADDR_W-1:0] bus_address = '0;
	logic [DATA_W-1:0] write_byte = '0;
	logic out_ready = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	logic in_ready;
	logic out_valid;
	logic [1:0] target;
	logic [PHYS_W-1:0] physical_address;
	logic [DATA_W-1:0] read_value;
	logic value_from_block;

	cartridge_bank_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.bus_address(bus_address),
		.write_byte(write_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.target(target),
		.physical_address(physical_address),
		.read_value(read_value),
		.value_from_block(value_from_block),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// decoder model: configuration copy
	kind_t            m_kind = KIND_NONE;
	logic [9:0]       m_rom_count = 10'd2;
	logic [4:0]       m_ram_count = 5'd1;
	logic             m_has_ram = 1'b0;

	// decoder model: bank state
	logic [8:0]       m_bank_lo = '0;
	logic [1:0]       m_bank_up = '0;
	logic             m_bank_mode = 1'b0;
	logic [1:0]       m_ram_bank_first = '0;
	logic [7:0]       m_ram_sel = '0;
	logic [3:0]       m_ram_bank_fifth = '0;
	logic [7:0]       m_rtc_file [RTC_REGS] = '{default: 8'h00};

	bus_result_t pending_results [$];
	stim_row_t   stim_table [$];

	int fail_count = 0;
	int checked = 0;
	int n_reads = 0;
	int n_writes = 0;
	int n_settings = 0;
	int in_stall_cycles = 0;
	logic tx_steady = 1'b0;
	logic rx_steady = 1'b0;
	logic hold_req = 1'b0;

	// translate one bus access and apply its side effects on the bank state
	function automatic bus_result_t decode_access(input logic wr, input logic [15:0] a,
			input logic [7:0] d);
		bus_result_t r;
		logic [8:0] bank;
		logic [8:0] rom_mask;
		logic [3:0] ram_mask;
		logic [3:0] rb;
		logic [7:0] v;
		logic [2:0] ridx;
		r.tgt = TGT_NONE;
		r.paddr = '0;
		r.rval = '0;
		r.fb = 1'b0;
		rom_mask = 9'(m_rom_count - 10'd1);
		ram_mask = 4'(m_ram_count - 5'd1);
		if (!a[15]) begin
			if (wr) begin
				// bank register writes
				case (a[15:13])
					REG_ROM_BANK: begin
						if (m_kind == KIND_FIFTH) begin
							if (!a[12])
								m_bank_lo = {m_bank_lo[8], d};
							else
								m_bank_lo = {d[0], m_bank_lo[7:0]};
						end else begin
							v = (d == 8'd0) ? 8'd1 : d;
							if (m_kind == KIND_FIRST)
								v = v & FIRST_MASK;
							else if (m_kind == KIND_THIRD)
								v = v & THIRD_MASK;
							m_bank_lo = {1'b0, v};
						end
					end
					REG_RAM_BANK: begin
						if (m_kind == KIND_FIRST) begin
							if (!m_bank_mode) begin
								m_bank_up = d[1:0];
							end else begin
								m_ram_bank_first = d[1:0];
								if (m_ram_count == 5'd1)
									m_ram_bank_first[1] = 1'b0;
							end
						end else if (m_kind == KIND_THIRD) begin
							m_ram_sel = d;
						end else if (m_kind == KIND_FIFTH) begin
							m_ram_bank_fifth = d[3:0] & ram_mask;
						end
					end
					REG_MODE: begin
						if (m_kind == KIND_FIRST)
							m_bank_mode = d[0];
					end
					default: ;
				endcase
			end else if (!a[14]) begin
				r.tgt = TGT_ROM;
				r.paddr = 23'(a);
			end else begin
				// switchable rom window
				bank = m_bank_lo;
				if (m_kind == KIND_FIRST && !m_bank_mode)
					bank = bank | (9'(m_bank_up) << 5);
				bank = bank & rom_mask;
				r.tgt = TGT_ROM;
				r.paddr = {bank, a[13:0]};
			end
		end else if (a[15:13] == REG_EXT_RAM) begin
			// external ram or rtc window
			if (m_kind == KIND_FIRST || m_kind == KIND_FIFTH) begin
				if (!m_has_ram) begin
					if (!wr) begin
						r.rval = UNMAPPED_READ;
						r.fb = 1'b1;
					end
				end else begin
					if (m_kind == KIND_FIRST)
						rb = m_bank_mode ? {2'b00, m_ram_bank_first} : 4'd0;
					else
						rb = m_ram_bank_fifth;
					r.tgt = TGT_RAM;
					r.paddr = 23'({rb, a[12:0]});
				end
			end else if (m_kind == KIND_THIRD && m_ram_sel < 8'd4) begin
				r.tgt = TGT_RAM;
				r.paddr = 23'({m_ram_sel[1:0], a[12:0]});
			end else if (m_kind == KIND_THIRD && m_ram_sel >= RTC_SEL_LO
					&& m_ram_sel <= RTC_SEL_HI) begin
				ridx = 3'(m_ram_sel - RTC_SEL_LO);
				r.tgt = TGT_RTC;
				r.paddr = 23'(ridx);
				if (wr) begin
					m_rtc_file[ridx] = d;
				end else begin
					r.rval = m_rtc_file[ridx];
					r.fb = 1'b1;
				end
			end else if (!wr) begin
				r.fb = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic bus_result_t mk_result(input target_t t, input logic [PHYS_W-1:0] p,
			input logic [DATA_W-1:0] v, input logic f);
		bus_result_t r;
		r.tgt = t;
		r.paddr = p;
		r.rval = v;
		r.fb = f;
		return r;
	endfunction

	function automatic void cfg_row(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		stim_row_t s;
		s.kind = ROW_CFG;
		s.idx = idx;
		s.cfg_val = val;
		s.wr = 1'b0;
		s.addr = '0;
		s.data = '0;
		s.known = '0;
		stim_table.push_back(s);
	endfunction

	function automatic void acc_row(input logic wr, input logic [15:0] a, input logic [7:0] d);
		stim_row_t s;
		s.kind = ROW_PREDICT;
		s.idx = '0;
		s.cfg_val = '0;
		s.wr = wr;
		s.addr = a;
		s.data = d;
		s.known = '0;
		stim_table.push_back(s);
	endfunction

	function automatic void typed_row(input logic wr, input logic [15:0] a, input logic [7:0] d,
			input bus_result_t known);
		stim_row_t s;
		s.kind = ROW_TYPED;
		s.idx = '0;
		s.cfg_val = '0;
		s.wr = wr;
		s.addr = a;
		s.data = d;
		s.known = known;
		stim_table.push_back(s);
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		return ($urandom_range(0, 15) == 0) ? int'($urandom_range(8, 40))
			: int'($urandom_range(1, 3));
	endfunction

	// offer one access word and record its expected result once accepted
	task automatic send_access(input logic wr, input logic [15:0] a, input logic [7:0] d,
			input logic typed, input bus_result_t known);
		int gap;
		bus_result_t pred;
		gap = tx_steady ? 0 : (($urandom_range(0, 2) == 0) ? pick_gap() : 0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= wr;
		bus_address <= a;
		write_byte <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pred = decode_access(wr, a, d);
		pending_results.push_back(typed ? known : pred);
		if (wr)
			n_writes++;
		else
			n_reads++;
	endtask

	// stop offering and wait until every expected result word is out
	task automatic drain_block();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_KIND:      m_kind = kind_t'(val[1:0]);
			CFG_ROM_COUNT: m_rom_count = val;
			CFG_RAM_COUNT: m_ram_count = val[4:0];
			CFG_HAS_RAM:   m_has_ram = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// one random access word, weighted toward meaningful register and window traffic
	task automatic send_random();
		int r;
		logic wr;
		logic [15:0] a;
		logic [7:0] d;
		r = $urandom_range(0, 99);
		d = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
		if (r < 15) begin
			wr = 1'b1;
			a = 16'h2000 | 16'($urandom_range(0, 16'h1fff));
		end else if (r < 25) begin
			wr = 1'b1;
			a = 16'h4000 | 16'($urandom_range(0, 16'h1fff));
			if ($urandom_range(0, 3) != 0)
				d = 8'($urandom_range(0, 12));
		end else if (r < 30) begin
			wr = 1'b1;
			a = 16'h6000 | 16'($urandom_range(0, 16'h1fff));
		end else if (r < 50) begin
			wr = 1'b0;
			a = 16'h4000 | 16'($urandom_range(0, 16'h3fff));
		end else if (r < 60) begin
			wr = 1'b0;
			a = 16'($urandom_range(0, 16'h3fff));
		end else if (r < 85) begin
			wr = 1'($urandom_range(0, 1));
			a = 16'ha000 | 16'($urandom_range(0, 16'h1fff));
		end else if (r < 95) begin
			wr = 1'($urandom_range(0, 1));
			a = 16'($urandom_range(0, 16'hffff));
		end else begin
			wr = 1'b1;
			a = 16'($urandom_range(0, 16'h1fff));
		end
		send_access(wr, a, d, 1'b0, '0);
	endtask

	// result word checker
	always @(posedge clk) begin : result_check
		bus_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result word: target %0d addr %h value %h fb %b",
						target, physical_address, read_value, value_from_block);
			end else begin
				exp_r = pending_results.pop_front();
				checked++;
				if (target !== exp_r.tgt || physical_address !== exp_r.paddr
						|| read_value !== exp_r.rval || value_from_block !== exp_r.fb) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch on word %0d: expected %0d %h %h %b, got %0d %h %h %b",
							checked, exp_r.tgt, exp_r.paddr, exp_r.rval, exp_r.fb,
							target, physical_address, read_value, value_from_block);
				end
			end
		end
		if (arst_n && in_valid && !in_ready)
			in_stall_cycles++;
	end

	// receiver: random stalls, steady stretches and one long hold-off on request
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				out_ready <= 1'b1;
			end else if (rx_steady) begin
				out_ready <= 1'b1;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// run limit
	initial begin
		#1_000_000;
		$display("watchdog expired with %0d result words outstanding", pending_results.size());
		$display("tb: failure");
		$finish;
	end

	initial begin : main
		int ph;
		int k;
		logic [1:0] rk;
		logic [9:0] rc;
		logic [4:0] mc;
		logic hr;

		// directed table, after reset: kind none, two rom banks, one ram bank, no ram
		typed_row(1'b0, 16'h0000, 8'h00, mk_result(TGT_ROM, 23'h0, 8'h00, 1'b0));
		typed_row(1'b0, 16'hffff, 8'hff, mk_result(TGT_NONE, 23'h0, 8'h00, 1'b0));
		typed_row(1'b0, 16'h4000, 8'h00, mk_result(TGT_ROM, 23'h0, 8'h00, 1'b0));
		typed_row(1'b0, 16'ha000, 8'h00, mk_result(TGT_NONE, 23'h0, 8'h00, 1'b1));
		typed_row(1'b1, 16'h2000, 8'hff, mk_result(TGT_NONE, 23'h0, 8'h00, 1'b0));
		typed_row(1'b1, 16'h0000, 8'h0a, mk_result(TGT_NONE, 23'h0, 8'h00, 1'b0));
		acc_row(1'b0, 16'h7fff, 8'h00);
		// first kind: bank zero, upper bits, no cartridge ram
		cfg_row(CFG_KIND, 10'(KIND_FIRST));
		cfg_row(CFG_ROM_COUNT, 10'd512);
		typed_row(1'b1, 16'h2000, 8'h00, mk_result(TGT_NONE, 23'h0, 8'h00, 1'b0));
		typed_row(1'b1, 16'h4000, 8'h03, mk_result(TGT_NONE, 23'h0, 8'h00, 1'b0));
		acc_row(1'b0, 16'h7fff, 8'h00);
		typed_row(1'b0, 16'ha123, 8'h00, mk_result(TGT_NONE, 23'h0, 8'hff, 1'b1));
		typed_row(1'b1, 16'hbfff, 8'h55, mk_result(TGT_NONE, 23'h0, 8'h00, 1'b0));
		// first kind with ram: rom mode uses bank 0, ram mode with one bank
		cfg_row(CFG_HAS_RAM, 10'd1);
		typed_row(1'b0, 16'ha000, 8'h00, mk_result(TGT_RAM, 23'h0, 8'h00, 1'b0));
		acc_row(1'b1, 16'h6000, 8'h01);
		acc_row(1'b1, 16'h4000, 8'h03);
		acc_row(1'b0, 16'hbfff, 8'h00);
		// third kind: rtc select, other select, ram select
		cfg_row(CFG_KIND, 10'(KIND_THIRD));
		acc_row(1'b1, 16'h4000, 8'h08);
		typed_row(1'b1, 16'ha000, 8'ha5, mk_result(TGT_RTC, 23'h0, 8'h00, 1'b0));
		acc_row(1'b0, 16'hb000, 8'h00);
		acc_row(1'b1, 16'h5fff, 8'h05);
		typed_row(1'b0, 16'ha000, 8'h00, mk_result(TGT_NONE, 23'h0, 8'h00, 1'b1));
		acc_row(1'b1, 16'h4000, 8'h03);
		acc_row(1'b0, 16'hbfff, 8'h00);
		// fifth kind with bank counts of zero: nine-bit bank, wrapped masks
		cfg_row(CFG_KIND, 10'(KIND_FIFTH));
		cfg_row(CFG_ROM_COUNT, 10'd0);
		cfg_row(CFG_RAM_COUNT, 10'd0);
		acc_row(1'b1, 16'h2000, 8'h00);
		acc_row(1'b1, 16'h3fff, 8'h01);
		acc_row(1'b0, 16'h4000, 8'h00);
		acc_row(1'b1, 16'h5fff, 8'hff);
		acc_row(1'b0, 16'ha000, 8'h00);
		cfg_row(CFG_RAM_COUNT, 10'd16);
		cfg_row(CFG_HAS_RAM, 10'd0);
		typed_row(1'b0, 16'hbfff, 8'h00, mk_result(TGT_NONE, 23'h0, 8'hff, 1'b1));

		// reset
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		foreach (stim_table[i]) begin
			if (stim_table[i].kind == ROW_CFG) begin
				drain_block();
				write_cfg(stim_table[i].idx, stim_table[i].cfg_val);
			end else begin
				send_access(stim_table[i].wr, stim_table[i].addr, stim_table[i].data,
					stim_table[i].kind == ROW_TYPED, stim_table[i].known);
			end
		end

		// random phases, each under its own bank setting
		for (ph = 0; ph < N_PHASES; ph++) begin
			drain_block();
			case (ph)
				0: begin
					rk = KIND_FIFTH; rc = 10'd512; mc = 5'd16; hr = 1'b1;
				end
				1: begin
					rk = KIND_FIRST; rc = 10'd2; mc = 5'd1; hr = 1'b0;
				end
				2: begin
					rk = KIND_THIRD; rc = 10'd512; mc = 5'd16; hr = 1'b1;
				end
				3: begin
					rk = KIND_FIRST; rc = 10'd512; mc = 5'd4; hr = 1'b1;
				end
				default: begin
					rk = 2'($urandom_range(0, 3));
					rc = ($urandom_range(0, 7) == 0) ? 10'd0 : 10'(1 << $urandom_range(1, 9));
					mc = ($urandom_range(0, 7) == 0) ? 5'd0 : 5'(1 << $urandom_range(0, 4));
					hr = 1'($urandom_range(0, 1));
				end
			endcase
			write_cfg(CFG_KIND, 10'(rk));
			write_cfg(CFG_ROM_COUNT, rc);
			write_cfg(CFG_RAM_COUNT, 10'(mc));
			write_cfg(CFG_HAS_RAM, 10'(hr));
			n_settings++;
			tx_steady = (ph % 4 == 1);
			rx_steady = (ph % 4 == 2);
			for (k = 0; k < PHASE_WORDS; k++) begin
				// long receiver hold-off while words keep coming, then a full pause
				if (ph == 3 && k == 20) begin
					tx_steady = 1'b1;
					hold_req = 1'b1;
				end
				if (ph == 3 && k == 45) begin
					tx_steady = 1'b0;
					drain_block();
				end
				send_random();
			end
		end

		// wind down
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("tb: %0d reads and %0d writes over %0d random bank settings plus the table",
			n_reads, n_writes, n_settings);
		$display("tb: %0d result words compared, input held back for %0d cycles",
			checked, in_stall_cycles);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: %0d failures, %0d words still expected", fail_count,
				pending_results.size());
			$display("tb: failure");
		end
		$finish;
	end

endmodule
